### hw/rtl/srrw_pkg.sv
// srrw_pkg: shared types and constants of the selective repeat receive window
// used by srrw_cell and selective_repeat_receive_window_top; no dependencies
package srrw_pkg;

    localparam int unsigned OFFSET_W  = 31;
    localparam int unsigned CHANNEL_W = 2;
    localparam int unsigned DATA_W    = 64;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned BASE_W    = 32;

    // result kinds
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // one incoming data packet
    typedef struct packed {
        logic [OFFSET_W-1:0]  byte_offset;
        logic [CHANNEL_W-1:0] channel;
        logic [DATA_W-1:0]    payload;
        logic [LEN_W-1:0]     payload_len;
        logic                 final_packet;
    } t_packet;

    // one result transaction
    typedef struct packed {
        logic                 kind;
        logic [OFFSET_W-1:0]  ack_offset;
        logic [CHANNEL_W-1:0] ack_channel;
        logic [DATA_W-1:0]    out_payload;
        logic [LEN_W-1:0]     out_len;
        logic                 stream_done;
        logic                 last;
    } t_result;

    // contents of one window cell
    typedef struct packed {
        logic              filled;
        logic [DATA_W-1:0] payload;
        logic [LEN_W-1:0]  len;
    } t_slot;

    // per-cell control from the sequencer
    typedef struct packed {
        logic write;
        logic shift;
    } t_cell_ctrl;

endpackage

### hw/rtl/srrw_cell.sv
// srrw_cell: one slot of the receive window shift chain
// depends on srrw_pkg
module srrw_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srrw_pkg::t_cell_ctrl        i_ctrl,
    input  logic [srrw_pkg::DATA_W-1:0] i_wr_payload,
    input  logic [srrw_pkg::LEN_W-1:0]  i_wr_len,
    input  srrw_pkg::t_slot             i_next,
    output srrw_pkg::t_slot             o_slot
);

    logic                        r_filled;
    logic [srrw_pkg::DATA_W-1:0] r_payload;
    logic [srrw_pkg::LEN_W-1:0]  r_len;

    // filled flag: set on store, taken from the upper neighbor on shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= 1'b0;
        end else if (i_ctrl.write) begin
            r_filled <= 1'b1;
        end else if (i_ctrl.shift) begin
            r_filled <= i_next.filled;
        end
    end

    // packet data, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctrl.write) begin
            r_payload <= i_wr_payload;
            r_len     <= i_wr_len;
        end else if (i_ctrl.shift) begin
            r_payload <= i_next.payload;
            r_len     <= i_next.len;
        end
    end

    assign o_slot.filled  = r_filled;
    assign o_slot.payload = r_payload;
    assign o_slot.len     = r_len;

endmodule

### hw/rtl/selective_repeat_receive_window_top.sv
// selective_repeat_receive_window_top: receiver window of a selective repeat link
// depends on srrw_pkg and srrw_cell
//
// Usage:
//   A packet is offered on i_packet with i_start; it is taken at the clock edge
//   where i_start is high and o_busy is low. o_busy stays high while the packet
//   is worked on.
//   Results leave on o_result, one per cycle, each marked by o_result_valid for
//   exactly one cycle; the receiver cannot stall them. An accepted packet gives
//   either no result (stale, ahead of the window, or stream finished) or one
//   acknowledge followed by zero or more in-order deliveries; o_result.last
//   marks the final result of the packet.
//   The packet index is formed by a reciprocal multiply registered at accept;
//   the acknowledge comes out the cycle after accept. Each delivery, but one
//   that finishes the stream, shifts the window cells down by one slot. A
//   packet releases 0 to WINDOW_SLOTS deliveries.
//   Reset (synchronous, active low) empties the window, sets the base to zero,
//   forgets any final packet and clears the finished flag.
module selective_repeat_receive_window_top #(
    parameter int unsigned WINDOW_SLOTS = 8,
    parameter int unsigned PACKET_BYTES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  srrw_pkg::t_packet i_packet,
    output logic              o_busy,
    output logic              o_result_valid,
    output srrw_pkg::t_result o_result
);

    localparam int unsigned SLOT_W   = $clog2(WINDOW_SLOTS);
    localparam int unsigned LOG_PB   = $clog2(PACKET_BYTES);
    localparam int unsigned SHIFT    = srrw_pkg::OFFSET_W + LOG_PB;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(PACKET_BYTES) - 64'd1) / 64'(PACKET_BYTES);
    localparam logic [31:0] RECIP    = RECIP_FULL[31:0];
    localparam int unsigned PROD_W   = srrw_pkg::OFFSET_W + 32;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_CHECK   = 3'b010,
        S_DELIVER = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [PROD_W-1:0]               r_prod;
    logic [srrw_pkg::OFFSET_W-1:0]   r_offset;
    logic [srrw_pkg::CHANNEL_W-1:0]  r_channel;
    logic [srrw_pkg::DATA_W-1:0]     r_payload;
    logic [srrw_pkg::LEN_W-1:0]      r_len;
    logic                            r_final;
    logic [srrw_pkg::BASE_W-1:0]     r_base;
    logic [srrw_pkg::BASE_W-1:0]     r_final_index;
    logic                            r_finished;

    logic                            accept;
    logic [srrw_pkg::LEN_W-1:0]      len_sat;
    logic [srrw_pkg::DATA_W-1:0]     pay_masked;
    logic [PROD_W-1:0]               prod_shifted;
    logic [srrw_pkg::OFFSET_W-1:0]   index;
    logic [srrw_pkg::BASE_W:0]       diff;
    logic                            in_window;
    logic [SLOT_W-1:0]               rel;
    logic                            store;
    logic                            shift;
    logic                            done;

    srrw_pkg::t_slot                 cell_out [WINDOW_SLOTS];

    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE);

    // saturate length and clear bytes past it
    always_comb begin
        if (i_packet.payload_len > srrw_pkg::LEN_W'(PACKET_BYTES)) begin
            len_sat = srrw_pkg::LEN_W'(PACKET_BYTES);
        end else begin
            len_sat = i_packet.payload_len;
        end
        for (int b = 0; b < 8; b++) begin
            pay_masked[8*b +: 8] = (srrw_pkg::LEN_W'(b) < len_sat) ?
                                   i_packet.payload[8*b +: 8] : 8'd0;
        end
    end

    // capture the transaction and start the reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod    <= PROD_W'(i_packet.byte_offset) * PROD_W'(RECIP);
            r_offset  <= i_packet.byte_offset;
            r_channel <= i_packet.channel;
            r_payload <= pay_masked;
            r_len     <= len_sat;
            r_final   <= i_packet.final_packet;
        end
    end

    // packet index and window position
    assign prod_shifted = r_prod >> SHIFT;
    assign index        = prod_shifted[srrw_pkg::OFFSET_W-1:0];
    assign diff         = {2'b00, index} - {1'b0, r_base};
    assign in_window    = !diff[srrw_pkg::BASE_W] &&
                          (diff[srrw_pkg::BASE_W-1:0] < srrw_pkg::BASE_W'(WINDOW_SLOTS));
    assign rel          = diff[SLOT_W-1:0];

    assign store = (r_state == S_CHECK) && !r_finished && in_window;
    assign done  = (r_base >= r_final_index);
    assign shift = (r_state == S_DELIVER) && !done;

    // chain of window cells, cell 0 holds the packet at the window base
    for (genvar g = 0; g < WINDOW_SLOTS; g++) begin : g_cell
        srrw_pkg::t_cell_ctrl ctrl;
        srrw_pkg::t_slot      next;

        assign ctrl.write = store && (rel == SLOT_W'(g));
        assign ctrl.shift = shift;
        if (g == WINDOW_SLOTS - 1) begin : g_end
            assign next = '0;
        end else begin : g_mid
            assign next = cell_out[g+1];
        end

        srrw_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_wr_payload(r_payload),
            .i_wr_len    (r_len),
            .i_next      (next),
            .o_slot      (cell_out[g])
        );
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (store && (rel == '0)) begin
                    n_state = S_DELIVER;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DELIVER: begin
                if (done || !cell_out[1].filled) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state: window base, final index, finished flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_base        <= '0;
            r_final_index <= '1;
            r_finished    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (store && r_final) begin
                r_final_index <= srrw_pkg::BASE_W'(index);
            end
            if (shift) begin
                r_base <= r_base + srrw_pkg::BASE_W'(1);
            end
            if ((r_state == S_DELIVER) && done) begin
                r_finished <= 1'b1;
            end
        end
    end

    // result transaction: acknowledge in check, delivery from cell 0
    always_comb begin
        o_result       = '0;
        o_result_valid = 1'b0;
        if (store) begin
            o_result_valid         = 1'b1;
            o_result.kind          = srrw_pkg::KIND_ACK;
            o_result.ack_offset    = r_offset;
            o_result.ack_channel   = r_channel;
            o_result.last          = (rel != '0);
        end else if (r_state == S_DELIVER) begin
            o_result_valid         = 1'b1;
            o_result.kind          = srrw_pkg::KIND_DATA;
            o_result.out_payload   = cell_out[0].payload;
            o_result.out_len       = cell_out[0].len;
            o_result.stream_done   = done;
            o_result.last          = done || !cell_out[1].filled;
        end
    end

endmodule

### test/selective_repeat_receive_window_top_tb.sv
`timescale 1ns / 1ps
// selective_repeat_receive_window_top_tb: self-checking bench for the receive window
// predicts acknowledge and in-order delivery transactions per packet and checks each one
// depends on srrw_pkg and selective_repeat_receive_window_top
module selective_repeat_receive_window_top_tb;

    localparam int unsigned WINDOW_SLOTS = 8;
    localparam int unsigned PACKET_BYTES = 8;
    localparam int unsigned DRAIN_CYCLES = WINDOW_SLOTS + 6;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    srrw_pkg::t_packet i_packet;
    logic              o_busy;
    logic              o_result_valid;
    srrw_pkg::t_result o_result;

    // window state as predicted
    logic [srrw_pkg::BASE_W-1:0] rx_base;
    logic                        held_valid [WINDOW_SLOTS];
    logic [srrw_pkg::DATA_W-1:0] held_data [WINDOW_SLOTS];
    logic [srrw_pkg::LEN_W-1:0]  held_len [WINDOW_SLOTS];
    logic [srrw_pkg::BASE_W-1:0] last_index;
    logic                        stream_over;

    srrw_pkg::t_result pending_results[$];
    int unsigned       error_count;
    bit                idle_bursts;

    selective_repeat_receive_window_top #(
        .WINDOW_SLOTS(WINDOW_SLOTS),
        .PACKET_BYTES(PACKET_BYTES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_packet       (i_packet),
        .o_busy         (o_busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // store one packet and queue its acknowledge plus the deliveries it releases
    function automatic void predict_window_results(input srrw_pkg::t_packet pkt);
        longint unsigned             idx;
        int unsigned                 slot_idx;
        int unsigned                 nbytes;
        logic [srrw_pkg::DATA_W-1:0] data;
        srrw_pkg::t_result           res;
        srrw_pkg::t_result           batch[$];
        bit                          done;
        if (stream_over) return;
        idx = pkt.byte_offset / PACKET_BYTES;
        // stale or ahead of the window: silently dropped
        if (idx < rx_base || idx >= 64'(rx_base) + WINDOW_SLOTS) return;
        // oversize length saturates, bytes past the length are cleared
        nbytes = (pkt.payload_len > PACKET_BYTES) ? PACKET_BYTES : pkt.payload_len;
        data = pkt.payload;
        if (nbytes < srrw_pkg::DATA_W / 8) data &= (64'd1 << (8 * nbytes)) - 64'd1;
        slot_idx = idx % WINDOW_SLOTS;
        held_valid[slot_idx] = 1'b1;
        held_data[slot_idx] = data;
        held_len[slot_idx] = nbytes[srrw_pkg::LEN_W-1:0];
        if (pkt.final_packet) last_index = idx[srrw_pkg::BASE_W-1:0];
        res = '0;
        res.kind = srrw_pkg::KIND_ACK;
        res.ack_offset = pkt.byte_offset;
        res.ack_channel = pkt.channel;
        batch.push_back(res);
        // release filled slots from the base onward
        for (int k = 0; k < WINDOW_SLOTS; k++) begin
            slot_idx = rx_base % WINDOW_SLOTS;
            if (!held_valid[slot_idx]) break;
            done = (rx_base >= last_index);
            res = '0;
            res.kind = srrw_pkg::KIND_DATA;
            res.out_payload = held_data[slot_idx];
            res.out_len = held_len[slot_idx];
            res.stream_done = done;
            batch.push_back(res);
            if (done) begin
                stream_over = 1'b1;
                break;
            end
            held_valid[slot_idx] = 1'b0;
            rx_base = rx_base + 1'b1;
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) pending_results.push_back(batch[i]);
    endfunction

    function automatic srrw_pkg::t_packet make_packet(
        input longint unsigned             byte_pos,
        input int unsigned                 chan,
        input logic [srrw_pkg::DATA_W-1:0] data,
        input int unsigned                 nbytes,
        input bit                          fin);
        srrw_pkg::t_packet pkt;
        pkt.byte_offset = byte_pos[srrw_pkg::OFFSET_W-1:0];
        pkt.channel = chan[srrw_pkg::CHANNEL_W-1:0];
        pkt.payload = data;
        pkt.payload_len = nbytes[srrw_pkg::LEN_W-1:0];
        pkt.final_packet = fin;
        return pkt;
    endfunction

    // byte offset somewhere inside packet idx
    function automatic longint unsigned index_offset(input longint unsigned idx);
        return idx * PACKET_BYTES + $urandom_range(0, PACKET_BYTES - 1);
    endfunction

    function automatic logic [srrw_pkg::DATA_W-1:0] random_data();
        return {$urandom, $urandom};
    endfunction

    function automatic void compare_field(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            error_count++;
        end
    endfunction

    // offer one packet, optionally after an idle burst, and wait for it to be taken
    task automatic send_packet(input srrw_pkg::t_packet pkt);
        int unsigned gap;
        if (idle_bursts && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 11);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_packet <= pkt;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predict_window_results(pkt);
    endtask

    // zero and all-ones fields, length saturation and masking
    task automatic test_field_extremes();
        send_packet(make_packet(0, 0, '0, 0, 1'b0));
        send_packet(make_packet(15, 3, '1, 8, 1'b0));
        send_packet(make_packet(16, 1, '1, 15, 1'b0));
        send_packet(make_packet(27, 2, random_data(), 9, 1'b0));
        send_packet(make_packet(32, 0, '1, 3, 1'b0));
    endtask

    // whole window filled backwards, released in one burst
    task automatic test_reorder_burst();
        longint unsigned b;
        b = rx_base;
        for (int k = WINDOW_SLOTS - 1; k >= 0; k--)
            send_packet(make_packet(index_offset(b + k), $urandom_range(0, 3), random_data(),
                                    $urandom_range(0, 15), 1'b0));
    endtask

    // duplicate inside the window overwrites its slot
    task automatic test_duplicate();
        longint unsigned b;
        b = rx_base;
        send_packet(make_packet(index_offset(b + 2), 1, random_data(), 5, 1'b0));
        send_packet(make_packet(index_offset(b + 2), 2, random_data(), 7, 1'b0));
        send_packet(make_packet(index_offset(b + 1), 3, random_data(), 8, 1'b0));
        send_packet(make_packet(index_offset(b), 0, random_data(), 2, 1'b0));
    endtask

    // stale packets give no transaction
    task automatic test_stale();
        send_packet(make_packet((64'(rx_base) - 1) * PACKET_BYTES + PACKET_BYTES - 1, 3,
                                random_data(), 4, 1'b0));
        send_packet(make_packet(0, 1, random_data(), 8, 1'b1));
    endtask

    // packets past the window give no transaction and leave the final mark alone
    task automatic test_ahead();
        send_packet(make_packet((64'(rx_base) + WINDOW_SLOTS) * PACKET_BYTES, 2,
                                random_data(), 6, 1'b1));
        send_packet(make_packet(64'h7FFF_FFFF, 3, '1, 15, 1'b1));
    endtask

    // mostly in-window traffic, some stale, ahead and arbitrary offsets
    task automatic test_random(input int unsigned count, input bit with_idle);
        longint unsigned idx;
        longint unsigned byte_pos;
        int unsigned     pick;
        bit              fin;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) idle_bursts = with_idle && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                byte_pos = index_offset(rx_base);
            end else if (pick < 75) begin
                byte_pos = index_offset(64'(rx_base) + $urandom_range(1, WINDOW_SLOTS - 1));
            end else if (pick < 85 && rx_base != 0) begin
                idx = rx_base - 1 - $urandom_range(0, (rx_base > 16) ? 15 : rx_base - 1);
                byte_pos = index_offset(idx);
            end else if (pick < 92) begin
                byte_pos = index_offset(64'(rx_base) + WINDOW_SLOTS + $urandom_range(0, 40));
            end else begin
                byte_pos = $urandom_range(0, 32'h7FFF_FFFF);
            end
            // a stored final flag would end the stream, so only dropped packets carry it
            idx = byte_pos / PACKET_BYTES;
            if (idx >= rx_base && idx < 64'(rx_base) + WINDOW_SLOTS) fin = 1'b0;
            else fin = $urandom_range(0, 1);
            send_packet(make_packet(byte_pos, $urandom_range(0, 3), random_data(),
                                    $urandom_range(0, 15), fin));
        end
    endtask

    // the latest stored final flag wins, even when it is the lower index
    task automatic test_repeated_final();
        longint unsigned b;
        b = rx_base;
        send_packet(make_packet(index_offset(b + 5), 1, random_data(), 8, 1'b1));
        send_packet(make_packet(index_offset(b + 2), 2, random_data(), 6, 1'b1));
        send_packet(make_packet(index_offset(b + 1), 3, random_data(), 11, 1'b0));
        send_packet(make_packet(index_offset(b + 3), 0, random_data(), 1, 1'b0));
        send_packet(make_packet(index_offset(b + 4), 1, random_data(), 8, 1'b0));
        send_packet(make_packet(index_offset(b), 2, random_data(), 4, 1'b0));
    endtask

    // once the stream is done every packet is ignored
    task automatic test_after_finish();
        send_packet(make_packet(index_offset(rx_base), 3, random_data(), 8, 1'b0));
        send_packet(make_packet(index_offset(64'(rx_base) + 1), 1, random_data(), 5, 1'b1));
        send_packet(make_packet(0, 0, '0, 0, 1'b0));
    endtask

    // check each result transaction against the oldest expectation
    always @(posedge i_clk) begin : result_check
        srrw_pkg::t_result want;
        if (i_rst_n && o_result_valid !== 1'b0) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_result);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("kind", want.kind, o_result.kind);
                compare_field("ack_offset", want.ack_offset, o_result.ack_offset);
                compare_field("ack_channel", want.ack_channel, o_result.ack_channel);
                compare_field("out_payload", want.out_payload, o_result.out_payload);
                compare_field("out_len", want.out_len, o_result.out_len);
                compare_field("stream_done", want.stream_done, o_result.stream_done);
                compare_field("last", want.last, o_result.last);
            end
        end
    end

    initial begin
        error_count = 0;
        idle_bursts = 1'b0;
        rx_base = '0;
        last_index = '1;
        stream_over = 1'b0;
        foreach (held_valid[i]) held_valid[i] = 1'b0;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_packet <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_bursts = 1'b1;
        test_field_extremes();
        test_reorder_burst();
        test_duplicate();
        test_stale();
        test_ahead();
        test_random(300, 1'b1);
        test_random(60, 1'b0);
        test_repeated_final();
        test_after_finish();
        i_start <= 1'b0;
        // drain outstanding transactions, then allow for a late extra one
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/srrw_pkg.sv
hw/rtl/srrw_cell.sv
hw/rtl/selective_repeat_receive_window_top.sv
test/selective_repeat_receive_window_top_tb.sv
